// ===== hw/rtl/dmrc_pkg.sv =====
package dmrc_pkg;

  localparam int unsigned SETS_DEFAULT = 256;

  localparam logic [15:0] REF_MAX = 16'hFFFF;

  localparam logic [2:0] ACT_LOOKUP    = 3'd0;
  localparam logic [2:0] ACT_REPLACE   = 3'd1;
  localparam logic [2:0] ACT_REMOVE    = 3'd2;
  localparam logic [2:0] ACT_RELEASE   = 3'd3;
  localparam logic [2:0] ACT_CLEAR     = 3'd4;
  localparam logic [2:0] ACT_CLEAR_ALL = 3'd5;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] page_id;
    logic [31:0] handle_in;
  } req_t;

  typedef struct packed {
    logic        status;
    logic [31:0] handle_out;
    logic [31:0] old_page_id;
    logic [31:0] hit_count;
    logic [31:0] miss_count;
  } rsp_t;

  typedef struct packed {
    logic [31:0] tag;
    logic [31:0] handle;
    logic [15:0] refs;
  } entry_t;

  typedef struct packed {
    logic        wr_en;
    entry_t      entry;
    logic        status;
    logic [31:0] handle_out;
    logic [31:0] old_page_id;
    logic        hit_inc;
    logic        miss_inc;
    logic        clr_cnt;
    logic        start_sweep;
  } upd_t;

  function automatic logic is_clear(input logic [2:0] action);
    return (action == ACT_CLEAR) || (action == ACT_CLEAR_ALL);
  endfunction

endpackage

// ===== hw/rtl/dmrc_set_index.sv =====
module dmrc_set_index #(
  parameter int unsigned SETS = dmrc_pkg::SETS_DEFAULT,
  parameter int unsigned IDX_W = $clog2(SETS)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  dmrc_pkg::req_t    in_req,
  output logic              out_valid,
  output dmrc_pkg::req_t    out_req,
  output logic [IDX_W-1:0]  set
);
  import dmrc_pkg::*;

  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / SETS);
  localparam logic [31:0] SETS_W = 32'(SETS);

  logic [63:0] prod;
  logic [31:0] quot;
  logic [31:0] rem_raw;
  logic [31:0] rem;

  // The estimated quotient is low by at most one, so one correction step suffices.
  assign prod = 64'(in_req.page_id) * 64'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_req <= in_req;
      quot    <= prod[63:32];
    end
  end

  always_comb begin
    rem_raw = out_req.page_id - 32'(quot * SETS_W);
    rem     = (rem_raw >= SETS_W) ? (rem_raw - SETS_W) : rem_raw;
  end

  assign set = rem[IDX_W-1:0];

endmodule

// ===== hw/rtl/dmrc_set_store.sv =====
module dmrc_set_store #(
  parameter int unsigned SETS = dmrc_pkg::SETS_DEFAULT,
  parameter int unsigned IDX_W = $clog2(SETS)
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [IDX_W-1:0]  rd_addr,
  output dmrc_pkg::entry_t  rd_data,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_addr,
  input  dmrc_pkg::entry_t  wr_data
);
  import dmrc_pkg::*;

  entry_t mem [SETS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // A write to the set being read in the same cycle is passed straight through.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

// ===== hw/rtl/dmrc_entry_update.sv =====
module dmrc_entry_update (
  input  dmrc_pkg::req_t   req,
  input  dmrc_pkg::entry_t entry,
  output dmrc_pkg::upd_t   upd
);
  import dmrc_pkg::*;

  logic tag_match;
  logic referenced;

  assign tag_match  = (entry.tag == req.page_id);
  assign referenced = (entry.refs != 16'd0);

  always_comb begin
    upd             = '0;
    upd.entry       = entry;
    unique case (req.action)
      ACT_LOOKUP: begin
        if (tag_match) begin
          upd.hit_inc    = 1'b1;
          upd.handle_out = entry.handle;
          upd.wr_en      = 1'b1;
          if (entry.refs != REF_MAX) begin
            upd.entry.refs = entry.refs + 16'd1;
          end
        end else begin
          upd.miss_inc = 1'b1;
          upd.status   = 1'b1;
        end
      end
      ACT_REPLACE: begin
        if (referenced) begin
          upd.status = 1'b1;
        end else begin
          upd.old_page_id  = entry.tag;
          upd.handle_out   = entry.handle;
          upd.wr_en        = 1'b1;
          upd.entry.tag    = req.page_id;
          upd.entry.handle = req.handle_in;
          upd.entry.refs   = 16'd1;
        end
      end
      ACT_REMOVE: begin
        if (referenced) begin
          upd.status = 1'b1;
        end else begin
          upd.wr_en = 1'b1;
          upd.entry = '0;
        end
      end
      ACT_RELEASE: begin
        if (!tag_match) begin
          upd.status = 1'b1;
        end else if (referenced) begin
          upd.wr_en      = 1'b1;
          upd.entry.refs = entry.refs - 16'd1;
        end
      end
      ACT_CLEAR: begin
        upd.start_sweep = 1'b1;
      end
      ACT_CLEAR_ALL: begin
        upd.start_sweep = 1'b1;
        upd.clr_cnt     = 1'b1;
      end
      default: begin
        upd.status = 1'b1;
      end
    endcase
  end

endmodule

// ===== hw/rtl/direct_mapped_refcount_page_cache_core.sv =====
// Direct-mapped page cache with a reference count per set.
// Request channel: req_valid, req_ready and req carry one word holding the
// action, the page id and the handle to install. Response channel: rsp_valid,
// rsp_ready and rsp carry one word per request with the status, the returned
// or displaced handle, the displaced page id and both running counters.
// A request passes the s0, s1, s2 and response registers, and one request can
// be accepted every cycle while the receiver keeps up and no clear is pending:
// the set index registers a reciprocal multiply, then corrects the quotient, and
// the set store is read as a request enters s2 and written back as it leaves,
// with the pending write forwarded to a following request for the same set.
// The clear actions wipe the store one set per cycle after their response has
// been produced; requests behind a clear are held off until the pipeline has
// drained and the wipe has finished.
// After reset the same wipe runs and req_ready stays low until it has finished.
// When the receiver stalls, the whole pipeline holds and req_ready drops.
module direct_mapped_refcount_page_cache_core #(
  parameter int unsigned SETS = dmrc_pkg::SETS_DEFAULT,
  parameter int unsigned IDX_W = $clog2(SETS)
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  dmrc_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output dmrc_pkg::rsp_t rsp
);
  import dmrc_pkg::*;

  logic             adv;
  logic             clr_pend;

  logic             s0_valid;
  req_t             s0_req;
  logic             s1_valid;
  req_t             s1_req;
  logic [IDX_W-1:0] s1_set;
  logic             s2_valid;
  req_t             s2_req;
  logic [IDX_W-1:0] s2_set;
  entry_t           s2_entry;
  upd_t             upd;

  logic             sweep;
  logic [IDX_W-1:0] sweep_idx;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;

  logic [31:0]      hits;
  logic [31:0]      misses;
  logic [31:0]      hits_next;
  logic [31:0]      misses_next;

  assign adv      = !rsp_valid || rsp_ready;
  assign clr_pend = (s0_valid && is_clear(s0_req.action))
                 || (s1_valid && is_clear(s1_req.action))
                 || (s2_valid && is_clear(s2_req.action));
  assign req_ready = adv && !sweep && !clr_pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (adv) begin
      s0_valid <= req_valid && req_ready;
    end
    if (req_valid && req_ready) begin
      s0_req <= req;
    end
  end

  dmrc_set_index #(
    .SETS  (SETS),
    .IDX_W (IDX_W)
  ) u_set_index (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (s0_valid),
    .in_req    (s0_req),
    .out_valid (s1_valid),
    .out_req   (s1_req),
    .set       (s1_set)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
    if (adv) begin
      s2_req <= s1_req;
      s2_set <= s1_set;
    end
  end

  dmrc_set_store #(
    .SETS  (SETS),
    .IDX_W (IDX_W)
  ) u_set_store (
    .clk     (clk),
    .rd_en   (adv),
    .rd_addr (s1_set),
    .rd_data (s2_entry),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  dmrc_entry_update u_entry_update (
    .req   (s2_req),
    .entry (s2_entry),
    .upd   (upd)
  );

  always_comb begin
    if (sweep) begin
      wr_en   = 1'b1;
      wr_addr = sweep_idx;
      wr_data = '0;
    end else begin
      wr_en   = adv && s2_valid && upd.wr_en;
      wr_addr = s2_set;
      wr_data = upd.entry;
    end
  end

  always_comb begin
    if (upd.clr_cnt) begin
      hits_next   = '0;
      misses_next = '0;
    end else begin
      hits_next   = hits + 32'(upd.hit_inc);
      misses_next = misses + 32'(upd.miss_inc);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep     <= 1'b1;
      sweep_idx <= '0;
      hits      <= '0;
      misses    <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (sweep) begin
        if (sweep_idx == IDX_W'(SETS - 1)) begin
          sweep <= 1'b0;
        end else begin
          sweep_idx <= sweep_idx + IDX_W'(1);
        end
      end else if (adv && s2_valid && upd.start_sweep) begin
        sweep     <= 1'b1;
        sweep_idx <= '0;
      end
      if (adv) begin
        rsp_valid <= s2_valid;
        if (s2_valid) begin
          hits   <= hits_next;
          misses <= misses_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_valid) begin
      rsp.status      <= upd.status;
      rsp.handle_out  <= upd.handle_out;
      rsp.old_page_id <= upd.old_page_id;
      rsp.hit_count   <= hits_next;
      rsp.miss_count  <= misses_next;
    end
  end

  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (rst)
    sweep |-> !req_ready)
    else $error("request accepted while the store is being wiped");

  a_sweep_pipeline_empty: assert property (@(posedge clk) disable iff (rst)
    sweep |-> !s2_valid)
    else $error("pipeline write competes with the wipe");

  a_sweep_start: assert property (@(posedge clk) disable iff (rst)
    $rose(sweep) |-> $past(adv && s2_valid && upd.start_sweep))
    else $error("wipe started without a clear action");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> (s2_valid == $past(s2_valid)) && $stable(s2_req) && $stable(s2_entry))
    else $error("pipeline moved while the response was stalled");

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  import dmrc_pkg::*;

  localparam int unsigned NUM_SETS   = SETS_DEFAULT;
  localparam int          IDLE_LIMIT = 4000;
  localparam int          RANDOM_WORDS = 500;

  class cache_mirror;
    logic [31:0] tags    [NUM_SETS];
    logic [31:0] handles [NUM_SETS];
    logic [15:0] refs    [NUM_SETS];
    logic [31:0] hits;
    logic [31:0] misses;
    rsp_t        due_rsps[$];
    int          errors;
    int          checked;
    int          lookup_hits;
    int          lookup_misses;
    int          refusals;
    int          clears;

    function new();
      foreach (tags[i]) begin
        tags[i]    = '0;
        handles[i] = '0;
        refs[i]    = '0;
      end
      hits   = '0;
      misses = '0;
    endfunction

    function void wipe_sets();
      foreach (tags[i]) begin
        tags[i]    = '0;
        handles[i] = '0;
        refs[i]    = '0;
      end
    endfunction

    function int pending();
      return due_rsps.size();
    endfunction

    function void predict(req_t w);
      rsp_t        e;
      int unsigned idx;
      e   = '0;
      idx = w.page_id % NUM_SETS;
      case (w.action)
        ACT_LOOKUP: begin
          if (tags[idx] == w.page_id) begin
            hits = hits + 32'd1;
            if (refs[idx] < REF_MAX) refs[idx] = refs[idx] + 16'd1;
            e.handle_out = handles[idx];
            lookup_hits++;
          end else begin
            misses   = misses + 32'd1;
            e.status = 1'b1;
            lookup_misses++;
          end
        end
        ACT_REPLACE: begin
          if (refs[idx] != '0) begin
            e.status = 1'b1;
            refusals++;
          end else begin
            e.old_page_id = tags[idx];
            e.handle_out  = handles[idx];
            tags[idx]     = w.page_id;
            handles[idx]  = w.handle_in;
            refs[idx]     = 16'd1;
          end
        end
        ACT_REMOVE: begin
          if (refs[idx] != '0) begin
            e.status = 1'b1;
            refusals++;
          end else begin
            tags[idx]    = '0;
            handles[idx] = '0;
          end
        end
        ACT_RELEASE: begin
          if (tags[idx] != w.page_id) e.status = 1'b1;
          else if (refs[idx] != '0) refs[idx] = refs[idx] - 16'd1;
        end
        ACT_CLEAR: begin
          wipe_sets();
          clears++;
        end
        ACT_CLEAR_ALL: begin
          wipe_sets();
          hits   = '0;
          misses = '0;
          clears++;
        end
        default: e.status = 1'b1;
      endcase
      e.hit_count  = hits;
      e.miss_count = misses;
      due_rsps.push_back(e);
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    function void compare_response(rsp_t got);
      rsp_t e;
      if (due_rsps.size() == 0) begin
        report($sformatf("Unexpected response word: %p", got));
        return;
      end
      e = due_rsps.pop_front();
      checked++;
      if (got.status !== e.status || got.handle_out !== e.handle_out ||
          got.old_page_id !== e.old_page_id || got.hit_count !== e.hit_count ||
          got.miss_count !== e.miss_count)
        report($sformatf("Response %0d mismatch: expected %p, got %p", checked, e, got));
    endfunction
  endclass

  logic  clk;
  logic  rst = 1'b1;
  logic  req_valid = 1'b0;
  logic  req_ready;
  req_t  req = '0;
  logic  rsp_valid;
  logic  rsp_ready = 1'b0;
  rsp_t  rsp;
  logic  no_gaps = 1'b0;
  int    sent;

  cache_mirror mirror = new();

  direct_mapped_refcount_page_cache_core uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    rsp_ready <= no_gaps || ($urandom_range(99) >= 11);
    if (!rst && rsp_valid && rsp_ready) mirror.compare_response(rsp);
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle = 0;
      else idle++;
    end
    $display("Timed out after %0d cycles with no word moving", IDLE_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic send_word(input logic [2:0] act, input logic [31:0] id,
                           input logic [31:0] hdl);
    req_t w;
    w.action    = act;
    w.page_id   = id;
    w.handle_in = hdl;
    while (!no_gaps && $urandom_range(99) < 11) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= w;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    mirror.predict(w);
    sent++;
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (mirror.pending() != 0) @(posedge clk);
  endtask

  // A well-formed life of one page: install, take references, drop them and
  // sometimes remove it.
  task automatic page_life(input logic [31:0] id);
    int k;
    int j;
    k = $urandom_range(1, 4);
    send_word(ACT_REPLACE, id, $urandom);
    for (j = 0; j < k; j++) send_word(ACT_LOOKUP, id, $urandom);
    for (j = 0; j < k + $urandom_range(0, 1); j++) send_word(ACT_RELEASE, id, $urandom);
    if ($urandom_range(2) == 0) send_word(ACT_REMOVE, id, $urandom);
  endtask

  initial begin
    logic [31:0] id_pool[24];
    logic [2:0]  act;
    logic [31:0] id;
    int          start;
    int          i;
    sent = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    send_word(ACT_LOOKUP,    32'h0000_0000, 32'h0000_0000);
    send_word(ACT_LOOKUP,    32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(ACT_REPLACE,   32'h0000_0000, 32'h1234_5678);
    send_word(ACT_REMOVE,    32'h0000_0100, $urandom);
    send_word(ACT_RELEASE,   32'h0000_0000, $urandom);
    send_word(ACT_RELEASE,   32'h0000_0000, $urandom);
    send_word(ACT_RELEASE,   32'h0000_0100, $urandom);
    send_word(ACT_REPLACE,   32'h0000_0100, 32'hFFFF_FFFF);
    send_word(ACT_LOOKUP,    32'h0000_0100, $urandom);
    send_word(ACT_RELEASE,   32'h0000_0100, $urandom);
    send_word(ACT_REMOVE,    32'h0001_2300, $urandom);
    send_word(ACT_LOOKUP,    32'h0000_0100, $urandom);
    send_word(ACT_REPLACE,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(ACT_REPLACE,   32'hFFFF_FFFF, 32'h0000_0001);
    send_word(ACT_RELEASE,   32'hFFFF_FFFF, $urandom);
    send_word(ACT_REPLACE,   32'h7FFF_FFFF, 32'h8000_0000);
    send_word(ACT_LOOKUP,    32'h7FFF_FFFF, $urandom);
    send_word(3'd6,          32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_word(3'd7,          32'h0000_0000, 32'h0000_0000);
    send_word(ACT_CLEAR,     $urandom,      $urandom);
    send_word(ACT_LOOKUP,    32'h7FFF_FFFF, $urandom);
    send_word(ACT_CLEAR_ALL, $urandom,      $urandom);
    send_word(ACT_LOOKUP,    32'h0000_0000, $urandom);
    drain();

    id_pool[0] = 32'h0000_0000;
    id_pool[1] = 32'hFFFF_FFFF;
    for (i = 2; i < 24; i++) id_pool[i] = ($urandom & 32'hFFFF_FF00) | $urandom_range(7);

    start = sent;
    while (sent - start < RANDOM_WORDS) begin
      no_gaps <= (sent - start >= 150) && (sent - start < 300);
      if (sent - start >= 250 && sent - start < 260) drain();
      if ($urandom_range(99) < 70) begin
        page_life(id_pool[$urandom_range(23)]);
      end else begin
        act = 3'($urandom_range(7));
        if ((act == ACT_CLEAR || act == ACT_CLEAR_ALL) && $urandom_range(3) != 0)
          act = ACT_LOOKUP;
        id = ($urandom_range(1) == 0) ? id_pool[$urandom_range(23)] : $urandom;
        send_word(act, id, $urandom);
      end
    end

    drain();
    repeat (20) @(posedge clk);
    $display("Sent %0d request words and checked %0d responses.", sent, mirror.checked);
    $display("Lookups hit %0d and missed %0d; %0d refusals and %0d clears were seen.",
             mirror.lookup_hits, mirror.lookup_misses, mirror.refusals, mirror.clears);
    if (mirror.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d errors found", mirror.errors);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
